// ===== sv/double_ended_surge_locator_core_macros.svh =====
`ifndef DOUBLE_ENDED_SURGE_LOCATOR_CORE_MACROS_SVH
`define DOUBLE_ENDED_SURGE_LOCATOR_CORE_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define DELS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication into the next cycle.
`define DELS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dels_pkg.sv =====
`timescale 1ns / 1ps

package dels_pkg;

    localparam int PH_W    = 2;
    localparam int SEC_W   = 17;
    localparam int NS_W    = 30;
    localparam int LEN_W   = 30;
    localparam int VF_W    = 17;
    localparam int DELTA_W = 31;

    // propagation constant, mm per ns at light speed
    localparam int SPEED_MM_PER_NS = 300;
    localparam int Q_SHIFT         = 16;

    localparam int MUL_W  = 32;
    localparam int K_W    = 26;           // 300 * vf < 2^26
    localparam int PROD_W = 58;           // |k * delta| < 2^56
    localparam int NUM_W  = 59;           // L<<16 minus product, signed

    localparam int S_TDATA_W = 48;        // second_tag, nanoseconds
    localparam int S_TUSER_W = 3;         // from_remote, phase
    localparam int M_TDATA_W = 96;        // delta_ns, dist_local_mm, dist_remote_mm
    localparam int M_TUSER_W = 2;         // located_phase

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VF  = 1'b1;

    localparam logic [VF_W-1:0] VF_RESET = 17'd43909;

    typedef struct packed {
        logic [SEC_W-1:0] sec;
        logic [NS_W-1:0]  ns;
    } t_rec;

endpackage

// ===== sv/double_ended_surge_locator_core.sv =====
// Channel   Dir  Beat contents (low bit first)
// s_axis    in   tuser: from_remote, phase; tdata: second_tag, nanoseconds
// m_axis    out  tuser: located_phase; tdata: delta_ns, dist_local_mm, dist_remote_mm
// cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, 0 = cable length, 1 = velocity factor
//
// One shared 32x32 signed multiplier forms 300*vf, then (300*vf)*delta.
// Ignored phase: beat dropped, core stays idle. Record without partner: lookup, then idle.
// Paired record: lookup, MUL_K, MUL_P, SUB, CHECK; result registered from CHECK.
// Synchronous active-low reset clears state, length, record and output valid bits; vf = VF_RESET.
// A held result does not block the next input beat; only the final step waits.
`timescale 1ns / 1ps

module double_ended_surge_locator_core
    import dels_pkg::*;
#(
    parameter int PHASES = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // [16:0] second_tag, [46:17] nanoseconds
    input  logic [S_TUSER_W-1:0]  s_axis_tuser,   // [0] from_remote, [2:1] phase
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [30:0] delta_ns, [60:31] dist_local_mm,
                                                  // [90:61] dist_remote_mm
    output logic [M_TUSER_W-1:0]  m_axis_tuser,   // [1:0] located_phase
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_MUL_K,
        ST_MUL_P,
        ST_SUB,
        ST_CHECK
    } t_state;

    t_state r_state, n_state;

    logic [LEN_W-1:0] r_len, n_len;
    logic [VF_W-1:0]  r_vf,  n_vf;

    logic [PHASES-1:0] r_loc_valid, n_loc_valid;
    logic [PHASES-1:0] r_rem_valid, n_rem_valid;
    t_rec              r_loc [PHASES];
    t_rec              n_loc [PHASES];
    t_rec              r_rem [PHASES];
    t_rec              n_rem [PHASES];

    logic [PH_W-1:0]          r_ph,    n_ph;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [K_W-1:0]           r_k,     n_k;
    logic signed [PROD_W-1:0] r_prod,  n_prod;
    logic signed [NUM_W-1:0]  r_num,   n_num;

    logic                     r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0]     r_m_data,  n_m_data;
    logic [M_TUSER_W-1:0]     r_m_user,  n_m_user;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;

    logic             in_fire, in_remote, in_ph_ok;
    logic [PH_W-1:0]  in_ph;
    t_rec             in_rec;
    t_rec             lo_rec, re_rec;
    logic             lo_ok, re_ok, out_free;
    logic signed [NUM_W-1:0] rem_num;

    assign in_remote = s_axis_tuser[0];
    assign in_ph     = s_axis_tuser[PH_W:1];
    assign in_rec    = '{sec: s_axis_tdata[SEC_W-1:0], ns: s_axis_tdata[SEC_W+NS_W-1:SEC_W]};
    assign in_ph_ok  = ({1'b0, in_ph} < (PH_W+1)'(PHASES));

    assign s_axis_tready = (r_state == ST_IDLE) && i_rst_n;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

    always_comb begin
        lo_rec = r_loc[0];
        re_rec = r_rem[0];
        lo_ok  = 1'b0;
        re_ok  = 1'b0;
        for (int i = 0; i < PHASES; i++) begin
            if (r_ph == PH_W'(i)) begin
                lo_rec = r_loc[i];
                re_rec = r_rem[i];
                lo_ok  = r_loc_valid[i];
                re_ok  = r_rem_valid[i];
            end
        end
    end

    always_comb begin
        mul_a = MUL_W'(signed'({1'b0, r_vf}));
        mul_b = MUL_W'(SPEED_MM_PER_NS);
        if (r_state == ST_MUL_P) begin
            mul_a = MUL_W'(signed'({1'b0, r_k}));
            mul_b = MUL_W'(r_delta);
        end
        mul_p = mul_a * mul_b;
    end

    // span minus numerator gives the remote distance
    assign rem_num = NUM_W'(signed'({1'b0, r_len, 17'b0})) - r_num;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_vf        = r_vf;
        n_loc_valid = r_loc_valid;
        n_rem_valid = r_rem_valid;
        n_loc       = r_loc;
        n_rem       = r_rem;
        n_ph        = r_ph;
        n_delta     = r_delta;
        n_k         = r_k;
        n_prod      = r_prod;
        n_num       = r_num;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEN: n_len = i_cfg_data[LEN_W-1:0];
                CFG_VF:  n_vf  = i_cfg_data[VF_W-1:0];
            endcase
        end

        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && in_ph_ok) begin
                    n_ph = in_ph;
                    for (int i = 0; i < PHASES; i++) begin
                        if (in_ph == PH_W'(i)) begin
                            if (in_remote) begin
                                n_rem[i]       = in_rec;
                                n_rem_valid[i] = 1'b1;
                            end else begin
                                n_loc[i]       = in_rec;
                                n_loc_valid[i] = 1'b1;
                            end
                        end
                    end
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_delta = signed'({1'b0, lo_rec.ns}) - signed'({1'b0, re_rec.ns});
                if (lo_ok && re_ok && (lo_rec.sec == re_rec.sec)) begin
                    n_state = ST_MUL_K;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL_K: begin
                n_k     = mul_p[K_W-1:0];
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                n_prod  = mul_p[PROD_W-1:0];
                n_state = ST_SUB;
            end
            ST_SUB: begin
                n_num   = NUM_W'(signed'({1'b0, r_len, 16'b0})) - NUM_W'(r_prod);
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_num[NUM_W-1] || rem_num[NUM_W-1]) begin
                    n_state = ST_IDLE;           // fault outside the line
                end else if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_user  = r_ph;
                    n_m_data  = {5'b0, rem_num[LEN_W+16:17], r_num[LEN_W+16:17],
                                 r_delta};
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_vf        <= VF_RESET;
            r_loc_valid <= '0;
            r_rem_valid <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_vf        <= n_vf;
            r_loc_valid <= n_loc_valid;
            r_rem_valid <= n_rem_valid;
            r_m_valid   <= n_m_valid;
        end
        r_loc    <= n_loc;
        r_rem    <= n_rem;
        r_ph     <= n_ph;
        r_delta  <= n_delta;
        r_k      <= n_k;
        r_prod   <= n_prod;
        r_num    <= n_num;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

endmodule

// ===== sv/dels_checker.sv =====
`timescale 1ns / 1ps
`include "double_ended_surge_locator_core_macros.svh"

module dels_checker
    import dels_pkg::*;
#(
    parameter int PHASES = 3
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TUSER_W-1:0] s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [M_TUSER_W-1:0] m_axis_tuser
);

    logic in_beat_ok;

    assign in_beat_ok = s_axis_tvalid && s_axis_tready &&
                        ({1'b0, s_axis_tuser[PH_W:1]} < (PH_W+1)'(PHASES));

    `DELS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "result beat changed while stalled")

    // a stored record keeps the input side busy for at least the lookup
    `DELS_ASSERT_NEXT(a_busy_after_rec, in_beat_ok, !s_axis_tready,
        "ready right after a record beat")

    `DELS_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready,
        !$rose(m_axis_tvalid), "result one cycle after an input beat")

    `DELS_ASSERT(a_phase_range,
        !m_axis_tvalid || ({1'b0, m_axis_tuser} < (PH_W+1)'(PHASES)),
        "located phase outside the channels")

    // non-negative delta: x <= L/2, so the fault lies in the local half
    `DELS_ASSERT(a_half_line,
        !(m_axis_tvalid && !m_axis_tdata[DELTA_W-1]) ||
        (m_axis_tdata[DELTA_W+LEN_W-1:DELTA_W] <= m_axis_tdata[DELTA_W+2*LEN_W-1:DELTA_W+LEN_W]),
        "non-negative delta but local distance beyond remote distance")

endmodule

bind double_ended_surge_locator_core dels_checker #(.PHASES(PHASES)) u_dels_checker (.*);
